// ===== rtl/tpp_pkg.sv =====
// Shared types, codes and arithmetic helpers for the thermal and power policy replay.
// No dependencies; used by every module of the block.
package tpp_pkg;

  // Action codes
  localparam logic [1:0] ACT_FULL   = 2'd0;
  localparam logic [1:0] ACT_GENTLE = 2'd1;
  localparam logic [1:0] ACT_STOP   = 2'd2;

  // Reason codes
  localparam logic [3:0] RSN_COOLDOWN   = 4'd0;
  localparam logic [3:0] RSN_LIMIT      = 4'd1;
  localparam logic [3:0] RSN_BATT_OFF   = 4'd2;
  localparam logic [3:0] RSN_FLOOR      = 4'd3;
  localparam logic [3:0] RSN_BATT_BAND  = 4'd4;
  localparam logic [3:0] RSN_WARM_CHG   = 4'd5;
  localparam logic [3:0] RSN_WARM       = 4'd6;
  localparam logic [3:0] RSN_NO_BATTERY = 4'd7;
  localparam logic [3:0] RSN_AC_BAND    = 4'd8;

  // Power source codes
  localparam logic [1:0] SRC_AC         = 2'd0;
  localparam logic [1:0] SRC_BATTERY    = 2'd1;
  localparam logic [1:0] SRC_NO_BATTERY = 2'd2;

  // Configuration register indexes
  localparam logic [2:0] REG_POLICY_MODES   = 3'd0;
  localparam logic [2:0] REG_BATTERY_LIMITS = 3'd1;
  localparam logic [2:0] REG_CHARGE_COOL    = 3'd2;
  localparam logic [2:0] REG_TEMP_GENTLE    = 3'd3;
  localparam logic [2:0] REG_TEMP_PAUSE     = 3'd4;
  localparam logic [2:0] REG_TEMP_RESUME    = 3'd5;
  localparam logic [2:0] REG_TEMP_CHG       = 3'd6;
  localparam logic [2:0] REG_HOT_REF        = 3'd7;

  localparam int CFG_W = 30;

  localparam logic [47:0] MAX48     = 48'hFFFF_FFFF_FFFF;
  localparam logic [62:0] MAX63     = 63'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [31:0] MAX32     = 32'hFFFF_FFFF;
  localparam logic [63:0] FNV_BASIS = 64'hcbf2_9ce4_8422_2325;
  localparam logic [63:0] FNV_PRIME = 64'h0000_0100_0000_01b3;

  // Classified item handed from the front to the back
  typedef struct packed {
    logic        first;
    logic [1:0]  act;
    logic [3:0]  rsn;
    logic [31:0] dur;
    logic [15:0] excess;   // running hot excess, zero when none
    logic        low;      // running on battery at or below low reference
  } item_t;

  // FNV-1a 64 multiply by the prime 2^40 + 0x1b3, modulo 2^64, as shifts and adds
  function automatic logic [63:0] fnv_mul(input logic [63:0] x);
    fnv_mul = (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
  endfunction

  // Saturating 48-bit add of a 32-bit duration
  function automatic logic [47:0] sat_add48(input logic [47:0] a, input logic [31:0] b);
    logic [48:0] s;
    s = {1'b0, a} + {17'd0, b};
    sat_add48 = s[48] ? MAX48 : s[47:0];
  endfunction

  // Saturating 63-bit add of a 48-bit product
  function automatic logic [62:0] sat_add63(input logic [62:0] a, input logic [47:0] b);
    logic [63:0] s;
    s = {1'b0, a} + {16'd0, b};
    sat_add63 = s[63] ? MAX63 : s[62:0];
  endfunction

  // Saturating 32-bit increment
  function automatic logic [31:0] sat_inc32(input logic [31:0] a);
    sat_inc32 = (a == MAX32) ? a : a + 32'd1;
  endfunction

endpackage

// ===== rtl/tpp_queue.sv =====
// Two-entry queue between the classifying front and the accumulating back.
// Depends on tpp_pkg for the item type.
module tpp_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  tpp_pkg::item_t push_data,
  output logic          full,
  input  logic          pop,
  output tpp_pkg::item_t pop_data,
  output logic          empty
);

  tpp_pkg::item_t entries [2];
  logic           wptr;
  logic           rptr;
  logic [1:0]     count;

  assign full     = (count == 2'd2);
  assign empty    = (count == 2'd0);
  assign pop_data = entries[rptr];

  // Advance pointers and count on each transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push && !full) begin
        wptr <= ~wptr;
      end
      if (pop && !empty) begin
        rptr <= ~rptr;
      end
      case ({push && !full, pop && !empty})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (push && !full) begin
      entries[wptr] <= push_data;
    end
  end

endmodule

// ===== rtl/tpp_front.sv =====
// Front end: configuration registers, cooldown state and the priority decision.
// Depends on tpp_pkg; feeds classified items to tpp_queue.
module tpp_front (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  logic [2:0]                cfg_index,
  input  logic [tpp_pkg::CFG_W-1:0] cfg_data,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      first_of_trace,
  input  logic [1:0]                source,
  input  logic                      pct_present,
  input  logic [13:0]               percent,
  input  logic                      temp_present,
  input  logic signed [15:0]        temperature,
  input  logic                      charging,
  input  logic [31:0]               duration_us,
  input  logic                      q_full,
  output logic                      q_push,
  output tpp_pkg::item_t            q_data
);

  logic [2:0]         policy_modes;
  logic [29:0]        battery_limits;
  logic [13:0]        charge_slow_below;
  logic signed [15:0] temp_gentle;
  logic signed [15:0] temp_pause;
  logic signed [15:0] temp_resume;
  logic signed [15:0] temp_charge_gentle;
  logic signed [15:0] hot_reference;
  logic               cooling;
  logic               cooling_next;

  logic               cool_in;
  logic               decided;
  logic [1:0]         act;
  logic [3:0]         rsn;
  logic [15:0]        floor_pct;
  logic [13:0]        low_ref;
  logic signed [16:0] diff;

  assign in_ready  = !q_full;
  assign q_push    = in_valid && !q_full;
  assign floor_pct = battery_limits[15:0];
  assign low_ref   = battery_limits[29:16];

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      policy_modes       <= '0;
      battery_limits     <= '0;
      charge_slow_below  <= '0;
      temp_gentle        <= '0;
      temp_pause         <= '0;
      temp_resume        <= '0;
      temp_charge_gentle <= '0;
      hot_reference      <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        tpp_pkg::REG_POLICY_MODES:   policy_modes       <= cfg_data[2:0];
        tpp_pkg::REG_BATTERY_LIMITS: battery_limits     <= cfg_data[29:0];
        tpp_pkg::REG_CHARGE_COOL:    charge_slow_below  <= cfg_data[13:0];
        tpp_pkg::REG_TEMP_GENTLE:    temp_gentle        <= cfg_data[15:0];
        tpp_pkg::REG_TEMP_PAUSE:     temp_pause         <= cfg_data[15:0];
        tpp_pkg::REG_TEMP_RESUME:    temp_resume        <= cfg_data[15:0];
        tpp_pkg::REG_TEMP_CHG:       temp_charge_gentle <= cfg_data[15:0];
        tpp_pkg::REG_HOT_REF:        hot_reference      <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Decide action and reason by fixed priority
  always_comb begin
    cool_in      = first_of_trace ? 1'b0 : cooling;
    cooling_next = cool_in;
    decided      = 1'b0;
    act          = tpp_pkg::ACT_STOP;
    rsn          = tpp_pkg::RSN_COOLDOWN;
    if (cool_in) begin
      if (temp_present && temperature <= temp_resume) begin
        cooling_next = 1'b0;
      end else begin
        decided = 1'b1;
      end
    end
    if (!decided) begin
      if (temp_present && temperature >= temp_pause) begin
        cooling_next = 1'b1;
        act          = tpp_pkg::ACT_STOP;
        rsn          = tpp_pkg::RSN_LIMIT;
      end else if (source == tpp_pkg::SRC_BATTERY) begin
        if (!policy_modes[0]) begin
          act = tpp_pkg::ACT_STOP;
          rsn = tpp_pkg::RSN_BATT_OFF;
        end else if (pct_present && {2'b00, percent} <= floor_pct) begin
          act = tpp_pkg::ACT_STOP;
          rsn = tpp_pkg::RSN_FLOOR;
        end else begin
          act = policy_modes[1] ? tpp_pkg::ACT_GENTLE : tpp_pkg::ACT_FULL;
          rsn = tpp_pkg::RSN_BATT_BAND;
        end
      end else if (charging && pct_present && percent < charge_slow_below &&
                   temp_present && temperature >= temp_charge_gentle) begin
        act = tpp_pkg::ACT_GENTLE;
        rsn = tpp_pkg::RSN_WARM_CHG;
      end else if (temp_present && temperature >= temp_gentle) begin
        act = tpp_pkg::ACT_GENTLE;
        rsn = tpp_pkg::RSN_WARM;
      end else begin
        act = policy_modes[2] ? tpp_pkg::ACT_GENTLE : tpp_pkg::ACT_FULL;
        rsn = (source == tpp_pkg::SRC_NO_BATTERY) ? tpp_pkg::RSN_NO_BATTERY
                                                  : tpp_pkg::RSN_AC_BAND;
      end
    end
  end

  // Classify hot excess and low-battery time for running items
  assign diff = {temperature[15], temperature} - {hot_reference[15], hot_reference};

  always_comb begin
    q_data.first  = first_of_trace;
    q_data.act    = act;
    q_data.rsn    = rsn;
    q_data.dur    = duration_us;
    q_data.excess = (act != tpp_pkg::ACT_STOP && temp_present && diff > 17'sd0)
                    ? diff[15:0] : 16'd0;
    q_data.low    = (act != tpp_pkg::ACT_STOP) && (source == tpp_pkg::SRC_BATTERY) &&
                    pct_present && (percent <= low_ref);
  end

  // Hold cooldown state, update on each transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      cooling <= 1'b0;
    end else if (q_push) begin
      cooling <= cooling_next;
    end
  end

endmodule

// ===== rtl/tpp_back.sv =====
// Back end: running totals, change counters and FNV-1a 64 checksum.
// Depends on tpp_pkg; drains tpp_queue and drives the result channel.
module tpp_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_empty,
  input  tpp_pkg::item_t q_data,
  output logic           q_pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [1:0]     action,
  output logic [3:0]     reason,
  output logic [47:0]    full_time,
  output logic [47:0]    gentle_time,
  output logic [47:0]    stop_time,
  output logic [47:0]    run_time,
  output logic [62:0]    hot_integral,
  output logic [47:0]    low_battery_time,
  output logic [31:0]    action_changes,
  output logic [31:0]    decision_changes,
  output logic [63:0]    checksum
);

  typedef enum logic {
    S_IDLE,
    S_CALC
  } state_t;

  state_t         state;
  tpp_pkg::item_t work;
  logic [47:0]    product;
  logic [63:0]    hash_half;
  logic           history_valid;
  logic           commit;
  logic [63:0]    hash_base;

  assign q_pop     = (state == S_IDLE) && !q_empty;
  assign commit    = (state == S_CALC) && (!out_valid || out_ready);
  assign hash_base = q_data.first ? tpp_pkg::FNV_BASIS : checksum;

  // Pop one item, multiply, then commit totals once the output is free
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      out_valid        <= 1'b0;
      history_valid    <= 1'b0;
      action           <= tpp_pkg::ACT_FULL;
      reason           <= tpp_pkg::RSN_COOLDOWN;
      full_time        <= '0;
      gentle_time      <= '0;
      stop_time        <= '0;
      run_time         <= '0;
      hot_integral     <= '0;
      low_battery_time <= '0;
      action_changes   <= '0;
      decision_changes <= '0;
      checksum         <= tpp_pkg::FNV_BASIS;
    end else begin
      // Raise valid on a commit, drop it once the result transfers
      if (commit) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (q_pop) begin
            work      <= q_data;
            product   <= {32'd0, q_data.excess} * {16'd0, q_data.dur};
            hash_half <= tpp_pkg::fnv_mul(hash_base ^ {62'd0, q_data.act});
            state     <= S_CALC;
          end
        end
        S_CALC: begin
          if (commit) begin
            // Time per action, cleared at the start of a trace
            full_time <= tpp_pkg::sat_add48(work.first ? 48'd0 : full_time,
                         (work.act == tpp_pkg::ACT_FULL) ? work.dur : 32'd0);
            gentle_time <= tpp_pkg::sat_add48(work.first ? 48'd0 : gentle_time,
                           (work.act == tpp_pkg::ACT_GENTLE) ? work.dur : 32'd0);
            stop_time <= tpp_pkg::sat_add48(work.first ? 48'd0 : stop_time,
                         (work.act == tpp_pkg::ACT_STOP) ? work.dur : 32'd0);
            run_time <= tpp_pkg::sat_add48(work.first ? 48'd0 : run_time,
                        (work.act != tpp_pkg::ACT_STOP) ? work.dur : 32'd0);
            hot_integral <= tpp_pkg::sat_add63(work.first ? 63'd0 : hot_integral,
                            product);
            low_battery_time <= tpp_pkg::sat_add48(
                                work.first ? 48'd0 : low_battery_time,
                                work.low ? work.dur : 32'd0);
            // Change counts skip the first item of a trace
            if (work.first) begin
              action_changes   <= '0;
              decision_changes <= '0;
            end else if (history_valid) begin
              if (work.act != action) begin
                action_changes <= tpp_pkg::sat_inc32(action_changes);
              end
              if (work.act != action || work.rsn != reason) begin
                decision_changes <= tpp_pkg::sat_inc32(decision_changes);
              end
            end
            history_valid <= 1'b1;
            action        <= work.act;
            reason        <= work.rsn;
            checksum      <= tpp_pkg::fnv_mul(hash_half ^ {60'd0, work.rsn});
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/thermal_power_policy_replay.sv =====
// Top level of the thermal and power policy replay block.
// Depends on tpp_pkg, tpp_front, tpp_queue and tpp_back.
//
// Usage:
//   Configuration is written through cfg_write / cfg_index / cfg_data, one
//   register per cycle, while the block is idle. Observations enter on the
//   in_valid / in_ready channel; each yields exactly one result on the
//   out_valid / out_ready channel carrying the action, the reason and all
//   running totals after that observation.
//   An accepted observation is written into the queue, then popped with
//   the excess multiply and first checksum round, then committed, which
//   raises out_valid; the commit waits while a result is still held.
//   The back end pops an item only when idle and commits totals and the
//   second checksum round before it pops the next. The front takes one
//   item per cycle into a two-entry queue while the queue is not full.
//   Reset: all configuration registers clear to zero, cooldown and history
//   clear, totals clear and the checksum loads the FNV-1a offset basis.
//   Stall: while out_ready is low the result holds; the back end keeps one
//   item ready to commit and the queue fills, after which in_ready drops.
module thermal_power_policy_replay (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  logic [2:0]                cfg_index,
  input  logic [tpp_pkg::CFG_W-1:0] cfg_data,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      first_of_trace,
  input  logic [1:0]                source,
  input  logic                      pct_present,
  input  logic [13:0]               percent,
  input  logic                      temp_present,
  input  logic signed [15:0]        temperature,
  input  logic                      charging,
  input  logic [31:0]               duration_us,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [1:0]                action,
  output logic [3:0]                reason,
  output logic [47:0]               full_time,
  output logic [47:0]               gentle_time,
  output logic [47:0]               stop_time,
  output logic [47:0]               run_time,
  output logic [62:0]               hot_integral,
  output logic [47:0]               low_battery_time,
  output logic [31:0]               action_changes,
  output logic [31:0]               decision_changes,
  output logic [63:0]               checksum
);

  logic           q_push;
  logic           q_full;
  logic           q_pop;
  logic           q_empty;
  tpp_pkg::item_t push_data;
  tpp_pkg::item_t pop_data;

  // Classify observations
  tpp_front u_front (
    .clk             (clk),
    .rst             (rst),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .first_of_trace  (first_of_trace),
    .source          (source),
    .pct_present     (pct_present),
    .percent         (percent),
    .temp_present    (temp_present),
    .temperature     (temperature),
    .charging        (charging),
    .duration_us     (duration_us),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_data          (push_data)
  );

  // Decouple front and back
  tpp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (pop_data),
    .empty     (q_empty)
  );

  // Accumulate totals and drive results
  tpp_back u_back (
    .clk              (clk),
    .rst              (rst),
    .q_empty          (q_empty),
    .q_data           (pop_data),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .action           (action),
    .reason           (reason),
    .full_time        (full_time),
    .gentle_time      (gentle_time),
    .stop_time        (stop_time),
    .run_time         (run_time),
    .hot_integral     (hot_integral),
    .low_battery_time (low_battery_time),
    .action_changes   (action_changes),
    .decision_changes (decision_changes),
    .checksum         (checksum)
  );

endmodule

// ===== bench/thermal_power_policy_replay_tb.sv =====
// Self-checking bench for thermal_power_policy_replay: a decision tracker predicts every
// result and compares it field by field. Depends on tpp_pkg and the block's RTL only.
module thermal_power_policy_replay_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tpp_pkg::*;

  // Unused source encoding, handled as ac by the block
  localparam logic [1:0] SRC_UNUSED = 2'd3;

  localparam logic [63:0] TIME_CAP     = 64'h0000_FFFF_FFFF_FFFF;
  localparam logic [63:0] HOT_CAP      = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] COUNT_CAP    = 64'h0000_0000_FFFF_FFFF;
  localparam logic [63:0] HASH_SEED    = 64'hcbf2_9ce4_8422_2325;
  localparam logic [63:0] HASH_MULT    = 64'h0000_0100_0000_01b3;
  localparam int          LONG_HOLD    = 200;
  localparam int          STREAK_ITEMS = 8;

  typedef struct packed {
    logic               first;
    logic [1:0]         source;
    logic               has_pct;
    logic [13:0]        pct;
    logic               has_temp;
    logic signed [15:0] temp;
    logic               charging;
    logic [31:0]        dur;
  } obs_t;

  typedef struct packed {
    logic [1:0]  act;
    logic [3:0]  rsn;
    logic [47:0] full_us;
    logic [47:0] gentle_us;
    logic [47:0] stop_us;
    logic [47:0] run_us;
    logic [62:0] hot;
    logic [47:0] low_us;
    logic [31:0] act_flips;
    logic [31:0] dec_flips;
    logic [63:0] hash;
  } verdict_t;

  typedef struct packed {
    logic [2:0]         modes;
    logic [29:0]        limits;
    logic [13:0]        cool_until;
    logic signed [15:0] gentle;
    logic signed [15:0] pause;
    logic signed [15:0] resume;
    logic signed [15:0] chg;
    logic signed [15:0] hot;
  } policy_t;

  // Predicts the decision and running totals for each accepted observation
  class decision_tracker;
    logic [2:0]         modes;
    logic [29:0]        limits;
    logic [13:0]        cool_until;
    logic signed [15:0] thr_gentle, thr_pause, thr_resume, thr_chg, thr_hot;

    bit          cooling;
    bit          have_last;
    logic [1:0]  last_act;
    logic [3:0]  last_rsn;
    logic [47:0] time_by_action [3];
    logic [47:0] running_us;
    logic [47:0] low_batt_us;
    logic [62:0] hot_sum;
    logic [31:0] act_flips;
    logic [31:0] dec_flips;
    logic [63:0] fnv;

    verdict_t    awaited_decisions [$];
    int unsigned failures;
    int unsigned checked;

    function new();
      modes = '0;
      limits = '0;
      cool_until = '0;
      thr_gentle = '0;
      thr_pause = '0;
      thr_resume = '0;
      thr_chg = '0;
      thr_hot = '0;
      failures = 0;
      checked = 0;
      clear_trace();
    endfunction

    function void clear_trace();
      cooling = 1'b0;
      have_last = 1'b0;
      last_act = '0;
      last_rsn = '0;
      foreach (time_by_action[i]) time_by_action[i] = '0;
      running_us = '0;
      low_batt_us = '0;
      hot_sum = '0;
      act_flips = '0;
      dec_flips = '0;
      fnv = HASH_SEED;
    endfunction

    function void load_register(logic [2:0] idx, logic [29:0] val);
      case (idx)
        REG_POLICY_MODES:   modes = val[2:0];
        REG_BATTERY_LIMITS: limits = val;
        REG_CHARGE_COOL:    cool_until = val[13:0];
        REG_TEMP_GENTLE:    thr_gentle = val[15:0];
        REG_TEMP_PAUSE:     thr_pause = val[15:0];
        REG_TEMP_RESUME:    thr_resume = val[15:0];
        REG_TEMP_CHG:       thr_chg = val[15:0];
        REG_HOT_REF:        thr_hot = val[15:0];
        default: ;
      endcase
    endfunction

    function logic [63:0] clip_add(logic [63:0] acc, logic [63:0] inc, logic [63:0] cap);
      if (acc >= cap || inc > cap - acc) return cap;
      return acc + inc;
    endfunction

    function int pending();
      return awaited_decisions.size();
    endfunction

    function void observe(obs_t o);
      verdict_t    v;
      logic [1:0]  act;
      logic [3:0]  rsn;
      bit          settled;
      int          excess;
      logic [63:0] prod;
      if (o.first) clear_trace();
      act = ACT_STOP;
      rsn = RSN_COOLDOWN;
      settled = 1'b0;
      // hold the cooldown until a reading at or below resume
      if (cooling) begin
        if (o.has_temp && o.temp <= thr_resume) cooling = 1'b0;
        else settled = 1'b1;
      end
      if (!settled) begin
        if (o.has_temp && o.temp >= thr_pause) begin
          cooling = 1'b1;
          act = ACT_STOP;
          rsn = RSN_LIMIT;
        end else if (o.source == SRC_BATTERY) begin
          if (!modes[0]) begin
            act = ACT_STOP;
            rsn = RSN_BATT_OFF;
          end else if (o.has_pct && o.pct <= limits[15:0]) begin
            act = ACT_STOP;
            rsn = RSN_FLOOR;
          end else begin
            act = modes[1] ? ACT_GENTLE : ACT_FULL;
            rsn = RSN_BATT_BAND;
          end
        end else if (o.charging && o.has_pct && o.pct < cool_until &&
                     o.has_temp && o.temp >= thr_chg) begin
          act = ACT_GENTLE;
          rsn = RSN_WARM_CHG;
        end else if (o.has_temp && o.temp >= thr_gentle) begin
          act = ACT_GENTLE;
          rsn = RSN_WARM;
        end else if (o.source == SRC_NO_BATTERY) begin
          act = modes[2] ? ACT_GENTLE : ACT_FULL;
          rsn = RSN_NO_BATTERY;
        end else begin
          act = modes[2] ? ACT_GENTLE : ACT_FULL;
          rsn = RSN_AC_BAND;
        end
      end
      // accumulate time, then the running-only totals
      time_by_action[act] = 48'(clip_add(64'(time_by_action[act]), 64'(o.dur), TIME_CAP));
      if (act != ACT_STOP) begin
        running_us = 48'(clip_add(64'(running_us), 64'(o.dur), TIME_CAP));
        excess = int'(o.temp) - int'(thr_hot);
        if (o.has_temp && excess > 0) begin
          prod = 64'(excess);
          prod = prod * o.dur;
          hot_sum = 63'(clip_add(64'(hot_sum), prod, HOT_CAP));
        end
        if (o.source == SRC_BATTERY && o.has_pct && o.pct <= limits[29:16])
          low_batt_us = 48'(clip_add(64'(low_batt_us), 64'(o.dur), TIME_CAP));
      end
      if (have_last) begin
        if (act != last_act)
          act_flips = 32'(clip_add(64'(act_flips), 64'd1, COUNT_CAP));
        if (act != last_act || rsn != last_rsn)
          dec_flips = 32'(clip_add(64'(dec_flips), 64'd1, COUNT_CAP));
      end
      have_last = 1'b1;
      last_act = act;
      last_rsn = rsn;
      fnv = (fnv ^ {62'd0, act}) * HASH_MULT;
      fnv = (fnv ^ {60'd0, rsn}) * HASH_MULT;
      v = {act, rsn, time_by_action[ACT_FULL], time_by_action[ACT_GENTLE],
           time_by_action[ACT_STOP], running_us, hot_sum, low_batt_us,
           act_flips, dec_flips, fnv};
      awaited_decisions.insert(awaited_decisions.size(), v);
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        failures++;
        $display("%0t ns: result %0d %s mismatch: expected 0x%0h, actual 0x%0h",
                 $time, checked, name, want, got);
      end
    endfunction

    function void check_decision(verdict_t got);
      verdict_t want;
      if (awaited_decisions.size() == 0) begin
        failures++;
        $display("%0t ns: result with no observation outstanding: action %0d reason %0d",
                 $time, got.act, got.rsn);
        return;
      end
      want = awaited_decisions.pop_front();
      compare_field("action", 64'(want.act), 64'(got.act));
      compare_field("reason", 64'(want.rsn), 64'(got.rsn));
      compare_field("full_time", 64'(want.full_us), 64'(got.full_us));
      compare_field("gentle_time", 64'(want.gentle_us), 64'(got.gentle_us));
      compare_field("stop_time", 64'(want.stop_us), 64'(got.stop_us));
      compare_field("run_time", 64'(want.run_us), 64'(got.run_us));
      compare_field("hot_integral", 64'(want.hot), 64'(got.hot));
      compare_field("low_battery_time", 64'(want.low_us), 64'(got.low_us));
      compare_field("action_changes", 64'(want.act_flips), 64'(got.act_flips));
      compare_field("decision_changes", 64'(want.dec_flips), 64'(got.dec_flips));
      compare_field("checksum", want.hash, got.hash);
      checked++;
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_write;
  logic [2:0]           cfg_index;
  logic [CFG_W-1:0]     cfg_data;
  logic                 in_valid;
  logic                 in_ready;
  logic                 first_of_trace;
  logic [1:0]           source;
  logic                 pct_present;
  logic [13:0]          percent;
  logic                 temp_present;
  logic signed [15:0]   temperature;
  logic                 charging;
  logic [31:0]          duration_us;
  logic                 out_valid;
  logic                 out_ready;
  logic [1:0]           action;
  logic [3:0]           reason;
  logic [47:0]          full_time;
  logic [47:0]          gentle_time;
  logic [47:0]          stop_time;
  logic [47:0]          run_time;
  logic [62:0]          hot_integral;
  logic [47:0]          low_battery_time;
  logic [31:0]          action_changes;
  logic [31:0]          decision_changes;
  logic [63:0]          checksum;

  decision_tracker book;
  bit              tx_idle = 1'b1;
  bit              rx_idle = 1'b1;
  bit              long_hold_req = 1'b0;

  thermal_power_policy_replay dut (
    .clk              (clk),
    .rst              (rst),
    .cfg_write        (cfg_write),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .first_of_trace   (first_of_trace),
    .source           (source),
    .pct_present      (pct_present),
    .percent          (percent),
    .temp_present     (temp_present),
    .temperature      (temperature),
    .charging         (charging),
    .duration_us      (duration_us),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .action           (action),
    .reason           (reason),
    .full_time        (full_time),
    .gentle_time      (gentle_time),
    .stop_time        (stop_time),
    .run_time         (run_time),
    .hot_integral     (hot_integral),
    .low_battery_time (low_battery_time),
    .action_changes   (action_changes),
    .decision_changes (decision_changes),
    .checksum         (checksum)
  );

  always #4 clk = ~clk;

  // Mostly back-to-back, sometimes a short gap, now and then a long pause
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic obs_t mk_obs(int first, logic [1:0] src, int hp, int pct, int ht,
                                  int temp, int chg, logic [31:0] dur);
    obs_t o;
    o.first = 1'(first);
    o.source = src;
    o.has_pct = 1'(hp);
    o.pct = 14'(pct);
    o.has_temp = 1'(ht);
    o.temp = 16'(temp);
    o.charging = 1'(chg);
    o.dur = dur;
    return o;
  endfunction

  function automatic policy_t mk_policy(logic [2:0] modes, logic [29:0] limits, int cool,
                                        int gentle, int pause, int resume, int chg, int hot);
    policy_t p;
    p.modes = modes;
    p.limits = limits;
    p.cool_until = 14'(cool);
    p.gentle = 16'(gentle);
    p.pause = 16'(pause);
    p.resume = 16'(resume);
    p.chg = 16'(chg);
    p.hot = 16'(hot);
    return p;
  endfunction

  // Thresholds kept in a sensible order: resume at or below pause, gentle near both
  function automatic policy_t rand_policy();
    int base;
    base = int'($urandom_range(0, 14000)) - 10000;
    return mk_policy(3'($urandom_range(0, 7)),
                     {14'($urandom_range(0, 10000)), 16'($urandom_range(0, 10000))},
                     $urandom_range(0, 10000),
                     base + int'($urandom_range(0, 5000)) - 1000,
                     base + int'($urandom_range(0, 6000)),
                     base,
                     int'($urandom_range(0, 30000)) - 10000,
                     int'($urandom_range(0, 30000)) - 10000);
  endfunction

  // Readings cluster around the thresholds so cooldown and the bands toggle often
  function automatic obs_t rand_obs(policy_t p);
    obs_t o;
    int   t;
    o.first = 1'b0;
    case ($urandom_range(0, 19))
      0:       o.source = SRC_UNUSED;
      1, 2, 3, 4, 5, 6: o.source = SRC_AC;
      7, 8, 9, 10, 11, 12, 13: o.source = SRC_BATTERY;
      default: o.source = SRC_NO_BATTERY;
    endcase
    o.has_pct = ($urandom_range(0, 99) < 85);
    o.has_temp = ($urandom_range(0, 99) < 85);
    o.charging = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 9))
      0: t = $urandom_range(0, 65535);
      1, 2, 3, 4: begin
        case ($urandom_range(0, 4))
          0: t = int'(p.pause);
          1: t = int'(p.resume);
          2: t = int'(p.gentle);
          3: t = int'(p.chg);
          default: t = int'(p.hot);
        endcase
        t = t + int'($urandom_range(0, 4)) - 2;
      end
      default: t = int'($urandom_range(0, 30000)) - 10000;
    endcase
    o.temp = 16'(t);
    case ($urandom_range(0, 9))
      0: t = $urandom_range(0, 16383);
      1, 2, 3: begin
        case ($urandom_range(0, 2))
          0: t = int'(p.limits[15:0]);
          1: t = int'(p.limits[29:16]);
          default: t = int'(p.cool_until);
        endcase
        t = t + int'($urandom_range(0, 4)) - 2;
        if (t < 0) t = 0;
        if (t > 16383) t = 16383;
      end
      default: t = $urandom_range(0, 10000);
    endcase
    o.pct = 14'(t);
    case ($urandom_range(0, 9))
      0: o.dur = '0;
      1: o.dur = '1;
      2, 3, 4, 5: o.dur = $urandom_range(0, 1000);
      default: o.dur = $urandom;
    endcase
    return o;
  endfunction

  // Present one observation, hold it until the transfer, then idle if asked
  task automatic send_obs(input obs_t o);
    int gap;
    in_valid <= 1'b1;
    first_of_trace <= o.first;
    source <= o.source;
    pct_present <= o.has_pct;
    percent <= o.pct;
    temp_present <= o.has_temp;
    temperature <= o.temp;
    charging <= o.charging;
    duration_us <= o.dur;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    book.observe(o);
    gap = tx_idle ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drop valid and wait until every predicted result has been taken
  task automatic drain();
    in_valid <= 1'b0;
    while (book.pending() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [29:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    book.load_register(idx, val);
  endtask

  task automatic apply_policy(input policy_t p);
    write_reg(REG_POLICY_MODES, 30'(p.modes));
    write_reg(REG_BATTERY_LIMITS, p.limits);
    write_reg(REG_CHARGE_COOL, 30'(p.cool_until));
    write_reg(REG_TEMP_GENTLE, {14'd0, p.gentle});
    write_reg(REG_TEMP_PAUSE, {14'd0, p.pause});
    write_reg(REG_TEMP_RESUME, {14'd0, p.resume});
    write_reg(REG_TEMP_CHG, {14'd0, p.chg});
    write_reg(REG_HOT_REF, {14'd0, p.hot});
    cfg_write <= 1'b0;
  endtask

  // Random traces under one policy; optionally a long sink hold-off and a source pause
  task automatic run_phase(input policy_t p, input int n_items, input bit with_hold,
                           input bit with_pause);
    obs_t o;
    int   left_in_trace;
    apply_policy(p);
    left_in_trace = 0;
    for (int k = 0; k < n_items; k++) begin
      if (with_hold && k == n_items / 3) long_hold_req = 1'b1;
      if (with_pause && k == n_items / 2) drain();
      o = rand_obs(p);
      if (left_in_trace == 0) begin
        o.first = 1'b1;
        left_in_trace = $urandom_range(2, 40);
      end else begin
        o.first = ($urandom_range(0, 99) < 3);
      end
      left_in_trace--;
      send_obs(o);
    end
    drain();
  endtask

  // Capture every result transfer
  always @(posedge clk) begin : result_capture
    verdict_t seen;
    if (!rst && out_valid && out_ready) begin
      seen = {action, reason, full_time, gentle_time, stop_time, run_time, hot_integral,
              low_battery_time, action_changes, decision_changes, checksum};
      book.check_decision(seen);
    end
  end

  // Result sink: random back-pressure, plus a long hold-off on request
  initial begin : result_sink
    int stall;
    stall = 0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        stall = LONG_HOLD;
      end else if (stall == 0 && rx_idle) begin
        stall = pick_gap();
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        stall--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Stop a run that goes on far beyond what a correct run needs
  initial begin : watchdog
    #10ms;
    $display("thermal_power_policy_replay_tb: FAIL");
    $finish;
  end

  initial begin : stimulus
    book = new();
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    first_of_trace = 1'b0;
    source = SRC_AC;
    pct_present = 1'b0;
    percent = '0;
    temp_present = 1'b0;
    temperature = '0;
    charging = 1'b0;
    duration_us = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed: every reason, hysteresis, missing readings, field extremes
    apply_policy(mk_policy(3'b001, {14'd2500, 16'd1500}, 8000, 4000, 6000, 5000, 3500, 3000));
    send_obs(mk_obs(1, SRC_AC, 0, 0, 0, 0, 0, 1000));
    send_obs(mk_obs(0, SRC_NO_BATTERY, 1, 10000, 1, 2000, 0, 0));
    send_obs(mk_obs(0, SRC_UNUSED, 1, 5000, 1, 1000, 0, 250));
    send_obs(mk_obs(0, SRC_BATTERY, 1, 16383, 1, -10000, 0, 32'hFFFF_FFFF));
    send_obs(mk_obs(0, SRC_BATTERY, 1, 2500, 1, 3500, 0, 5000));
    send_obs(mk_obs(0, SRC_BATTERY, 1, 1500, 1, 2000, 0, 700));
    send_obs(mk_obs(0, SRC_BATTERY, 0, 0, 0, 0, 0, 300));
    send_obs(mk_obs(0, SRC_AC, 1, 7999, 1, 3500, 1, 400));
    send_obs(mk_obs(0, SRC_AC, 1, 8000, 1, 3500, 1, 400));
    send_obs(mk_obs(0, SRC_AC, 1, 0, 0, 0, 1, 400));
    send_obs(mk_obs(0, SRC_AC, 0, 0, 1, 4000, 0, 900));
    send_obs(mk_obs(0, SRC_NO_BATTERY, 0, 0, 1, 6000, 0, 100));
    send_obs(mk_obs(0, SRC_AC, 0, 0, 1, 5500, 0, 100));
    send_obs(mk_obs(0, SRC_AC, 0, 0, 0, 0, 0, 100));
    send_obs(mk_obs(0, SRC_AC, 0, 0, 1, 5000, 0, 100));
    send_obs(mk_obs(0, SRC_AC, 0, 0, 1, 32767, 0, 100));
    send_obs(mk_obs(0, SRC_BATTERY, 1, 5000, 1, -32768, 0, 100));
    send_obs(mk_obs(0, SRC_AC, 0, 0, 1, 7000, 0, 50));
    send_obs(mk_obs(1, SRC_AC, 0, 0, 1, 5500, 0, 60));
    send_obs(mk_obs(0, SRC_AC, 1, 0, 1, -1, 0, 32'h8000_0000));
    drain();
    apply_policy(mk_policy(3'b110, 30'h3FFF_FFFF, 16383, 20000, 20000, -10000, -10000,
                           -10000));
    send_obs(mk_obs(1, SRC_BATTERY, 1, 0, 1, 0, 0, 10));
    send_obs(mk_obs(0, SRC_AC, 1, 16382, 1, -10000, 1, 10));
    send_obs(mk_obs(0, SRC_NO_BATTERY, 0, 0, 0, 0, 0, 10));
    send_obs(mk_obs(0, SRC_AC, 0, 0, 0, 0, 0, 10));
    send_obs(mk_obs(0, SRC_AC, 0, 0, 1, 20000, 0, 10));
    drain();

    // A short stretch at full rate with no idling on either side, maximum duration:
    // a running stretch with the largest hot excess, then a cooldown stretch
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    apply_policy(mk_policy(3'b011, {14'h3FFF, 16'd0}, 0, 0, 32767, -32768, 0, -32768));
    for (int k = 0; k < STREAK_ITEMS; k++)
      send_obs(mk_obs(int'(k == 0), SRC_BATTERY, 1, 100, 1, 32766, 0, 32'hFFFF_FFFF));
    for (int k = 0; k < STREAK_ITEMS; k++)
      send_obs(mk_obs(0, SRC_BATTERY, 1, 100, 1, 32767, 0, 32'hFFFF_FFFF));
    drain();
    tx_idle = 1'b1;
    rx_idle = 1'b1;

    // Random traces under extreme and random policies
    run_phase(mk_policy(3'b111, 30'h3FFF_FFFF, 16383, 32767, 32767, 32767, 32767, 32767),
              50, 1'b0, 1'b0);
    run_phase(mk_policy(3'b000, 30'd0, 0, -32768, -32768, -32768, -32768, -32768),
              50, 1'b0, 1'b0);
    run_phase(mk_policy(3'b101, {14'd10000, 16'd10000}, 10000, 20000, 20000, -10000,
                        -10000, -10000), 50, 1'b0, 1'b0);
    run_phase(rand_policy(), 70, 1'b1, 1'b0);
    run_phase(rand_policy(), 70, 1'b0, 1'b1);
    run_phase(rand_policy(), 70, 1'b0, 1'b0);
    run_phase(rand_policy(), 70, 1'b0, 1'b0);

    // Let any stray result surface before judging
    repeat (20) @(posedge clk);
    if (book.failures == 0) begin
      $display("thermal_power_policy_replay_tb: PASS");
    end else begin
      $display("thermal_power_policy_replay_tb: FAIL");
    end
    $finish;
  end

endmodule
